FILE: rtl/ati_pkg.sv
// ============================================================================
// ati_pkg: shared types, constants and functions of the tilt orientation block
// Holds the fixed-point widths, the CORDIC angle table and helper functions.
// ============================================================================
package ati_pkg;

    localparam int SAMPLE_WIDTH  = 13;
    localparam int CORDIC_STAGES = 18;

    localparam int FRAC_W = 16;
    localparam int CW     = SAMPLE_WIDTH + FRAC_W + 4;
    localparam int ACC_W  = 26;
    localparam int DEG_W  = ACC_W - FRAC_W;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH;
    localparam int RT_W   = SAMPLE_WIDTH + FRAC_W;
    localparam int REM_W  = RT_W + 3;
    localparam int IDX_W  = 5;
    localparam int IN_TW  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TW = 24;
    localparam int LAT    = RT_W + CORDIC_STAGES + 4;

    localparam logic signed [ACC_W-1:0] ANG_90  = ACC_W'(90 * 65536);
    localparam logic signed [ACC_W-1:0] ANG_180 = ACC_W'(180 * 65536);

    typedef enum logic [2:0] {
        ORI_UP      = 3'd0,
        ORI_DOWN    = 3'd1,
        ORI_LEFT    = 3'd2,
        ORI_RIGHT   = 3'd3,
        ORI_FORWARD = 3'd4,
        ORI_BACK    = 3'd5
    } t_orient;

    typedef struct packed {
        logic signed [CW-1:0]    a;
        logic signed [CW-1:0]    b;
        logic signed [ACC_W-1:0] acc;
    } t_cvec;

    typedef struct packed {
        logic [SQ_W-1:0]  n;
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  res;
    } t_sqrt;

    function automatic logic signed [ACC_W-1:0] atan_tab(input logic [IDX_W-1:0] i);
        logic signed [ACC_W-1:0] v;
        case (i)
            5'd0:    v = ACC_W'(2949120);
            5'd1:    v = ACC_W'(1740967);
            5'd2:    v = ACC_W'(919879);
            5'd3:    v = ACC_W'(466945);
            5'd4:    v = ACC_W'(234379);
            5'd5:    v = ACC_W'(117304);
            5'd6:    v = ACC_W'(58666);
            5'd7:    v = ACC_W'(29335);
            5'd8:    v = ACC_W'(14668);
            5'd9:    v = ACC_W'(7334);
            5'd10:   v = ACC_W'(3667);
            5'd11:   v = ACC_W'(1833);
            5'd12:   v = ACC_W'(917);
            5'd13:   v = ACC_W'(458);
            5'd14:   v = ACC_W'(229);
            5'd15:   v = ACC_W'(115);
            5'd16:   v = ACC_W'(57);
            5'd17:   v = ACC_W'(29);
            5'd18:   v = ACC_W'(14);
            5'd19:   v = ACC_W'(7);
            5'd20:   v = ACC_W'(4);
            5'd21:   v = ACC_W'(2);
            5'd22:   v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Brings the vector into the right half plane and settles the axis cases.
    function automatic t_cvec cordic_pre(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
        t_cvec v;
        v.a   = a;
        v.b   = b;
        v.acc = '0;
        if (b == '0) begin
            if (a < 0) begin
                v.acc = ANG_180;
            end
        end else if (a == '0) begin
            v.acc = (b > 0) ? ANG_90 : -ANG_90;
            v.b   = '0;
        end else if (a < 0) begin
            if (b > 0) begin
                v.a   = b;
                v.b   = -a;
                v.acc = ANG_90;
            end else begin
                v.a   = -b;
                v.b   = a;
                v.acc = -ANG_90;
            end
        end
        return v;
    endfunction

    // Truncates a fixed-point angle toward zero and clamps it to the limit.
    function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [ACC_W-1:0] q,
                                                      input logic [DEG_W-1:0] lim);
        logic [ACC_W-1:0] mag;
        logic [DEG_W-1:0] d;
        mag = q[ACC_W-1] ? ACC_W'(-q) : ACC_W'(q);
        d   = mag[ACC_W-1:FRAC_W];
        if (d > lim) begin
            d = lim;
        end
        return q[ACC_W-1] ? -$signed(d) : $signed(d);
    endfunction

endpackage

FILE: rtl/ati_front.sv
// ============================================================================
// ati_front: input stages of the tilt orientation pipeline
// Squares the lateral axes, picks the orientation and prepares the roll vector.
// ============================================================================
module ati_front import ati_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_z,
    output t_sqrt                          o_sq,
    output t_cvec                          o_roll,
    output logic signed [SAMPLE_WIDTH-1:0] o_x,
    output t_orient                        o_ori
);

    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y, r_z, r_x2;
    logic        [SQ_W-1:0]         r_ysq, r_zsq;
    t_orient                        r_ori, r_ori2, n_ori;
    t_sqrt                          r_sq;
    t_cvec                          r_roll;
    logic        [SAMPLE_WIDTH:0]   ax, ay, az;
    logic signed [CW-1:0]           ya, za;
    t_sqrt                          n_sq;

    always_comb begin
        ax = i_x[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-i_x) : (SAMPLE_WIDTH+1)'(i_x);
        ay = i_y[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-i_y) : (SAMPLE_WIDTH+1)'(i_y);
        az = i_z[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-i_z) : (SAMPLE_WIDTH+1)'(i_z);
        ax = i_x[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-(SAMPLE_WIDTH+1)'(i_x)) : ax;
        ay = i_y[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-(SAMPLE_WIDTH+1)'(i_y)) : ay;
        az = i_z[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-(SAMPLE_WIDTH+1)'(i_z)) : az;
        if (az >= ax && az >= ay) begin
            n_ori = i_z[SAMPLE_WIDTH-1] ? ORI_DOWN : ORI_UP;
        end else if (ax >= ay) begin
            n_ori = i_x[SAMPLE_WIDTH-1] ? ORI_RIGHT : ORI_LEFT;
        end else begin
            n_ori = i_y[SAMPLE_WIDTH-1] ? ORI_BACK : ORI_FORWARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_ysq <= SQ_W'(i_y * i_y);
            r_zsq <= SQ_W'(i_z * i_z);
            r_ori <= n_ori;
        end
    end

    always_comb begin
        ya       = {{(CW-SAMPLE_WIDTH-FRAC_W){r_y[SAMPLE_WIDTH-1]}}, r_y, {FRAC_W{1'b0}}};
        za       = {{(CW-SAMPLE_WIDTH-FRAC_W){r_z[SAMPLE_WIDTH-1]}}, r_z, {FRAC_W{1'b0}}};
        n_sq.n   = r_ysq + r_zsq;
        n_sq.rem = '0;
        n_sq.res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_roll <= cordic_pre(za, ya);
            r_x2   <= r_x;
            r_ori2 <= r_ori;
        end
    end

    assign o_sq   = r_sq;
    assign o_roll = r_roll;
    assign o_x    = r_x2;
    assign o_ori  = r_ori2;

endmodule

FILE: rtl/ati_sqrt_stage.sv
// ============================================================================
// ati_sqrt_stage: one step of the pipelined integer square root
// Brings in two radicand bits and settles one root bit per cycle while enabled.
// ============================================================================
module ati_sqrt_stage import ati_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_st,
    output t_sqrt o_st
);

    t_sqrt            r_st, n_st;
    logic [REM_W-1:0] rem_s, trial;

    always_comb begin
        rem_s  = {i_st.rem[REM_W-3:0], i_st.n[SQ_W-1 -: 2]};
        trial  = {1'b0, i_st.res, 2'b01};
        n_st.n = {i_st.n[SQ_W-3:0], 2'b00};
        if (rem_s >= trial) begin
            n_st.rem = rem_s - trial;
            n_st.res = {i_st.res[RT_W-2:0], 1'b1};
        end else begin
            n_st.rem = rem_s;
            n_st.res = {i_st.res[RT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

FILE: rtl/ati_cordic_stage.sv
// ============================================================================
// ati_cordic_stage: one vectoring CORDIC rotation
// Turns the vector toward the x axis and accumulates the table angle.
// ============================================================================
module ati_cordic_stage import ati_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cvec            i_vec,
    output t_cvec            o_vec
);

    t_cvec                r_vec, n_vec;
    logic signed [CW-1:0] da, db;

    always_comb begin
        da    = i_vec.b >>> i_idx;
        db    = i_vec.a >>> i_idx;
        n_vec = i_vec;
        if (i_vec.b != '0) begin
            if (!i_vec.b[CW-1]) begin
                n_vec.a   = i_vec.a + da;
                n_vec.b   = i_vec.b - db;
                n_vec.acc = i_vec.acc + atan_tab(i_idx);
            end else begin
                n_vec.a   = i_vec.a - da;
                n_vec.b   = i_vec.b + db;
                n_vec.acc = i_vec.acc - atan_tab(i_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

FILE: rtl/accel_tilt_orientation.sv
// Throughput: one sample per cycle while the holding register is empty; every stage advances together.
// The square root takes one stage per root bit and each CORDIC rotation one stage.
// A result that is not taken moves into an output holding register; the pipeline
// and the input hold only while that register is full.
// Reset clears the valid bits only; the data registers keep their contents.
// ============================================================================
// accel_tilt_orientation: pitch, roll and orientation from a 3-axis sample
// Pipelined square root followed by vectoring CORDIC for pitch; roll CORDIC runs beside the root.
// ============================================================================
module accel_tilt_orientation import ati_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,  // accel_x, accel_y, accel_z, zero fill
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata   // pitch, roll, orientation, zero fill
);

    logic                           en;
    logic [LAT-1:0]                 r_vld;
    t_sqrt                          f_sq;
    t_cvec                          f_roll;
    logic signed [SAMPLE_WIDTH-1:0] f_x;
    t_orient                        f_ori;

    t_sqrt                          sq_pipe   [RT_W];
    t_cvec                          roll_pipe [RT_W];
    logic signed [SAMPLE_WIDTH-1:0] r_x_p     [RT_W];
    t_orient                        r_ori_p   [RT_W];

    t_cvec                          r_pv;
    logic signed [DEG_W-1:0]        r_rd0;
    t_orient                        r_or0;
    t_cvec                          pc        [CORDIC_STAGES];
    logic signed [DEG_W-1:0]        r_rd      [CORDIC_STAGES];
    t_orient                        r_or      [CORDIC_STAGES];

    logic signed [CW-1:0]           den, nx;
    logic signed [DEG_W-1:0]        pitch_full;
    logic signed [7:0]              r_pitch;
    logic signed [8:0]              r_roll;
    t_orient                        r_ori;

    logic [OUT_TW-1:0]              pipe_data;
    logic                           r_skid_vld;
    logic [OUT_TW-1:0]              r_skid_data;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_skid_vld || r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    ati_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_y    (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_z    (s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
        .o_sq   (f_sq),
        .o_roll (f_roll),
        .o_x    (f_x),
        .o_ori  (f_ori)
    );

    for (genvar k = 0; k < RT_W; k++) begin : g_root
        t_cvec roll_in;
        t_sqrt sq_in;
        if (k == 0) begin : g_first
            assign roll_in = f_roll;
            assign sq_in   = f_sq;
        end else begin : g_next
            assign roll_in = roll_pipe[k-1];
            assign sq_in   = sq_pipe[k-1];
        end

        ati_sqrt_stage u_sqrt (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (sq_in),
            .o_st  (sq_pipe[k])
        );

        if (k < CORDIC_STAGES) begin : g_rot
            ati_cordic_stage u_roll (
                .i_clk (i_clk),
                .i_en  (en),
                .i_idx (IDX_W'(k)),
                .i_vec (roll_in),
                .o_vec (roll_pipe[k])
            );
        end else begin : g_hold
            t_cvec r_hold;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_hold <= roll_in;
                end
            end
            assign roll_pipe[k] = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_p[0]   <= f_x;
            r_ori_p[0] <= f_ori;
            for (int k = 1; k < RT_W; k++) begin
                r_x_p[k]   <= r_x_p[k-1];
                r_ori_p[k] <= r_ori_p[k-1];
            end
        end
    end

    always_comb begin
        den = CW'($signed({1'b0, sq_pipe[RT_W-1].res}));
        nx  = -$signed({{(CW-SAMPLE_WIDTH-FRAC_W){r_x_p[RT_W-1][SAMPLE_WIDTH-1]}},
                        r_x_p[RT_W-1], {FRAC_W{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pv  <= cordic_pre(den, nx);
            r_rd0 <= to_deg(roll_pipe[RT_W-1].acc, DEG_W'(180));
            r_or0 <= r_ori_p[RT_W-1];
        end
    end

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_pitch
        t_cvec pin;
        if (j == 0) begin : g_first
            assign pin = r_pv;
        end else begin : g_next
            assign pin = pc[j-1];
        end

        ati_cordic_stage u_pitch (
            .i_clk (i_clk),
            .i_en  (en),
            .i_idx (IDX_W'(j)),
            .i_vec (pin),
            .o_vec (pc[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd[0] <= r_rd0;
            r_or[0] <= r_or0;
            for (int j = 1; j < CORDIC_STAGES; j++) begin
                r_rd[j] <= r_rd[j-1];
                r_or[j] <= r_or[j-1];
            end
        end
    end

    assign pitch_full = to_deg(pc[CORDIC_STAGES-1].acc, DEG_W'(90));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch <= pitch_full[7:0];
            r_roll  <= r_rd[CORDIC_STAGES-1][8:0];
            r_ori   <= r_or[CORDIC_STAGES-1];
        end
    end

    assign pipe_data = {{(OUT_TW-20){1'b0}}, r_ori, r_roll, r_pitch};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAT-1] && !m_axis_tready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_data <= pipe_data;
        end
    end

    assign m_axis_tdata = r_skid_vld ? r_skid_data : pipe_data;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) <= 90 &&
                           $signed(m_axis_tdata[7:0]) >= -90))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[16:8]) <= 180 &&
                           $signed(m_axis_tdata[16:8]) >= -180))
        else $error("roll out of range");

    a_ori_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19:17] <= ORI_BACK))
        else $error("orientation code out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && $past(i_rst_n)) |=> $stable(r_vld))
        else $error("valid pipeline moved during a stall");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !m_axis_tready) |=> (r_skid_vld && $stable(r_skid_data)))
        else $error("held result changed before it was taken");

endmodule

FILE: dv/accel_tilt_orientation_chk.sv
// ============================================================================
// accel_tilt_orientation_chk: result checker for the tilt orientation block
// Watches both stream channels, predicts pitch, roll and orientation for each
// accepted request and compares every result with the oldest prediction.
// ============================================================================
module accel_tilt_orientation_chk import ati_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [IN_TW-1:0]  i_req_data,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [OUT_TW-1:0] i_res_data,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [7:0] pitch;
        logic signed [8:0] roll;
        t_orient           ori;
    } t_tilt;

    t_tilt tilt_q[$];

    function automatic longint atan_step(input int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                            29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    // atan2(b, a) in degrees with 16 fractional bits.
    function automatic longint vector_angle(input longint a, input longint b);
        longint acc, t, da, db;
        acc = 0;
        if (b == 0) return (a >= 0) ? 0 : 180 * 65536;
        if (a == 0) return (b > 0) ? 90 * 65536 : -90 * 65536;
        if (a < 0) begin
            t = a;
            if (b > 0) begin
                a = b; b = -t; acc = 90 * 65536;
            end else begin
                a = -b; b = t; acc = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (b != 0) begin
                da = b >>> i;
                db = a >>> i;
                if (b > 0) begin
                    a += da; b -= db; acc += atan_step(i);
                end else begin
                    a -= da; b += db; acc -= atan_step(i);
                end
            end
        end
        return acc;
    endfunction

    function automatic longint whole_degrees(input longint q, input longint lim);
        longint d;
        d = (q >= 0) ? (q >>> 16) : -((-q) >>> 16);
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return d;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic t_tilt predict_tilt(input logic [IN_TW-1:0] d);
        t_tilt r;
        longint x, y, z, ax, ay, az, den;
        x = longint'($signed(d[SAMPLE_WIDTH-1:0]));
        y = longint'($signed(d[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
        z = longint'($signed(d[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        den = int_sqrt(longint'(y * y + z * z) << 32);
        r.roll  = 9'(whole_degrees(vector_angle(z * 65536, y * 65536), 180));
        r.pitch = 8'(whole_degrees(vector_angle(den, -x * 65536), 90));
        if (az >= ax && az >= ay) r.ori = (z >= 0) ? ORI_UP : ORI_DOWN;
        else if (ax >= ay) r.ori = (x >= 0) ? ORI_LEFT : ORI_RIGHT;
        else r.ori = (y >= 0) ? ORI_FORWARD : ORI_BACK;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = tilt_q.size();

    always @(posedge i_clk) begin
        t_tilt e;
        if (i_rst_n && i_req_valid && i_req_ready) begin
            tilt_q.push_back(predict_tilt(i_req_data));
        end
        if (i_rst_n && i_res_valid && i_res_ready) begin
            if (tilt_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", i_res_data));
            end else begin
                e = tilt_q.pop_front();
                if (i_res_data[7:0] !== e.pitch)
                    report_mismatch($sformatf("pitch %0d, expected %0d",
                        $signed(i_res_data[7:0]), e.pitch));
                if (i_res_data[16:8] !== e.roll)
                    report_mismatch($sformatf("roll %0d, expected %0d",
                        $signed(i_res_data[16:8]), e.roll));
                if (i_res_data[19:17] !== e.ori)
                    report_mismatch($sformatf("orientation %0d, expected %0d",
                        i_res_data[19:17], e.ori));
            end
        end
    end
endmodule

FILE: dv/accel_tilt_orientation_tb.sv
// ============================================================================
// accel_tilt_orientation_tb: stimulus and verdict for the tilt orientation block
// Drives directed corner samples and random samples with random gaps on both
// channels; the checker beside the block predicts and compares results.
// ============================================================================
module accel_tilt_orientation_tb import ati_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;
    localparam int NUM_RANDOM = 530;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    int                errors;
    int                pending;
    int                idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    accel_tilt_orientation uut (.*);

    accel_tilt_orientation_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] random_axis();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 13'h1000;
            1: return 13'h0fff;
            2: return '0;
            3: return SAMPLE_WIDTH'($urandom_range(0, 15));
            4: return -SAMPLE_WIDTH'($urandom_range(0, 15));
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] x,
                               input logic [SAMPLE_WIDTH-1:0] y,
                               input logic [SAMPLE_WIDTH-1:0] z);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata  <= IN_TW'({z, y, x});
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Result side stalls: random ready with occasional long holds.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = 0;
            if ($urandom_range(0, 3) == 0) begin
                g = gap_length();
            end
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [SAMPLE_WIDTH-1:0] cx[12] = '{13'h0fff, 13'h1000, 0, 0, 0, 0,
                                            100, 100, 13'h1f9c, 50, 13'h1000, 7};
        logic [SAMPLE_WIDTH-1:0] cy[12] = '{0, 0, 13'h0fff, 13'h1000, 0, 100,
                                            100, 0, 13'h1f9c, 50, 13'h1000, 13'h1ff9};
        logic [SAMPLE_WIDTH-1:0] cz[12] = '{0, 0, 0, 0, 0, 100, 13'h1f9c,
                                            13'h1f9c, 100, 50, 13'h1000, 13'h1ff9};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 12; i++) send_sample(cx[i], cy[i], cz[i]);
        // Axis-only vectors of both signs, zero-abscissa/ordinate cases and equal-magnitude ties.
        send_sample(0, 0, 13'h0fff);
        send_sample(0, 0, 13'h1000);
        send_sample(0, 13'h1fff, 13'h1000);
        send_sample(0, 1, 13'h1000);
        send_sample(13'h0fff, 13'h0fff, 13'h0fff);
        send_sample(13'h1000, 13'h0fff, 13'h1000);
        send_sample(1, 0, 0);
        send_sample(13'h1fff, 13'h1fff, 0);
        for (int i = 0; i < NUM_RANDOM; i++)
            send_sample(random_axis(), random_axis(), random_axis());
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3 * LAT) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/ati_pkg.sv
rtl/ati_front.sv
rtl/ati_sqrt_stage.sv
rtl/ati_cordic_stage.sv
rtl/accel_tilt_orientation.sv
dv/accel_tilt_orientation_chk.sv
dv/accel_tilt_orientation_tb.sv
